FILE: rtl/bcrd_pkg.sv
// Shared types and constants for the binned count record deframer.
// No dependencies; every other file in rtl/ imports this package.
package bcrd_pkg;

	localparam int DATA_W    = 8;
	localparam int LEN_W     = 16;
	localparam int FMT_W     = 16;
	localparam int STAMP_W   = 48;
	localparam int TIME_W    = 49;
	localparam int IDX_W     = 12;
	localparam int NB_W      = 13;
	localparam int POS_W     = 4;
	localparam int SPAN_SH   = 16;

	localparam int MAX_BINS  = 4096;
	localparam int BIN_W     = $clog2(MAX_BINS + 1);
	localparam int HDR_BYTES = 10;

	localparam logic [FMT_W-1:0] FORMAT_RESET = 16'd300;
	localparam logic [NB_W-1:0]  NB_SAT       = {NB_W{1'b1}};

	localparam int QUEUE_DEPTH_DEF = 2;

	typedef enum logic [1:0] {
		KIND_HEADER  = 2'd0,
		KIND_BIN     = 2'd1,
		KIND_ERR_FMT = 2'd2,
		KIND_ERR_BIN = 2'd3
	} kind_t;

	// One classified work item handed from the parser to the output side.
	typedef struct packed {
		kind_t              kind;
		logic [STAMP_W-1:0] stamp;
		logic [IDX_W-1:0]   index;
		logic [DATA_W-1:0]  count;
		logic [LEN_W-1:0]   length;
		logic [NB_W-1:0]    nbins;
		logic               gap;
		logic               ooo;
		logic               last;
		logic [FMT_W-1:0]   format;
	} cmd_t;

endpackage

FILE: rtl/bcrd_front.sv
// Byte parser: walks the record header, checks the format word and the bin count,
// and turns each byte into at most one command. Depends on bcrd_pkg.
module bcrd_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       byte_accept,
	input  logic [bcrd_pkg::DATA_W-1:0] data_byte,
	input  logic [bcrd_pkg::FMT_W-1:0]  expected_format,
	output logic                       cmd_push,
	output bcrd_pkg::cmd_t             cmd
);
	import bcrd_pkg::*;

	localparam logic [POS_W-1:0] POS_LEN_LO  = POS_W'(1);
	localparam logic [POS_W-1:0] POS_FMT     = POS_W'(2);
	localparam logic [POS_W-1:0] POS_FMT_LO  = POS_W'(3);
	localparam logic [POS_W-1:0] POS_STAMP   = POS_W'(4);
	localparam logic [POS_W-1:0] POS_LAST    = POS_W'(HDR_BYTES - 1);

	logic [POS_W-1:0]   pos_q;
	logic [LEN_W-1:0]   length_q;
	logic [FMT_W-1:0]   format_q;
	logic [STAMP_W-1:0] stamp_q;
	logic [LEN_W-1:0]   nb_q;
	logic [TIME_W-1:0]  expect_q;
	logic               prev_nz_q;
	logic [BIN_W-1:0]   bins_before_q;
	logic [BIN_W-1:0]   bins_left_q;
	logic [IDX_W-1:0]   bin_ctr_q;
	logic               halted_q;

	logic [LEN_W-1:0]   len_new;
	logic [FMT_W-1:0]   fmt_new;
	logic [STAMP_W-1:0] stamp_new;
	logic               work;
	logic               too_many;

	assign len_new   = {length_q[LEN_W-DATA_W-1:0], data_byte};
	assign fmt_new   = {format_q[FMT_W-DATA_W-1:0], data_byte};
	assign stamp_new = {stamp_q[STAMP_W-DATA_W-1:0], data_byte};
	assign work      = byte_accept && !halted_q;
	assign too_many  = nb_q > LEN_W'(MAX_BINS);

	always_comb begin
		cmd_push   = 1'b0;
		cmd        = '0;
		cmd.kind   = KIND_HEADER;
		cmd.length = length_q;
		cmd.format = format_q;
		if (work) begin
			if (bins_left_q != '0) begin
				cmd_push  = 1'b1;
				cmd.kind  = KIND_BIN;
				cmd.stamp = stamp_q;
				cmd.index = bin_ctr_q;
				cmd.count = data_byte;
				cmd.nbins = NB_W'(bins_before_q);
				cmd.last  = (bins_left_q == BIN_W'(1));
			end else if (pos_q == POS_FMT_LO) begin
				if (fmt_new != expected_format) begin
					cmd_push   = 1'b1;
					cmd.kind   = KIND_ERR_FMT;
					cmd.format = fmt_new;
				end
			end else if (pos_q == POS_LAST) begin
				cmd_push  = 1'b1;
				cmd.stamp = stamp_new;
				if (too_many) begin
					cmd.kind  = KIND_ERR_BIN;
					cmd.nbins = (nb_q > LEN_W'(NB_SAT)) ? NB_SAT : NB_W'(nb_q);
				end else begin
					cmd.kind  = KIND_HEADER;
					cmd.nbins = NB_W'(nb_q);
					// A zero previous stamp means there is nothing to compare against.
					cmd.gap   = prev_nz_q && ({1'b0, stamp_new} > expect_q);
					cmd.ooo   = prev_nz_q && ({1'b0, stamp_new} < expect_q);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q         <= '0;
			length_q      <= '0;
			format_q      <= '0;
			stamp_q       <= '0;
			nb_q          <= '0;
			expect_q      <= '0;
			prev_nz_q     <= 1'b0;
			bins_before_q <= '0;
			bins_left_q   <= '0;
			bin_ctr_q     <= '0;
			halted_q      <= 1'b0;
		end else if (work) begin
			if (bins_left_q != '0) begin
				bins_left_q <= bins_left_q - BIN_W'(1);
				bin_ctr_q   <= bin_ctr_q + IDX_W'(1);
			end else if (pos_q < POS_FMT) begin
				length_q <= len_new;
				pos_q    <= pos_q + POS_W'(1);
				if (pos_q == POS_LEN_LO) begin
					nb_q <= (len_new >= LEN_W'(HDR_BYTES)) ? len_new - LEN_W'(HDR_BYTES) : '0;
				end
			end else if (pos_q < POS_STAMP) begin
				format_q <= fmt_new;
				pos_q    <= pos_q + POS_W'(1);
				if (pos_q == POS_FMT_LO && fmt_new != expected_format) begin
					halted_q <= 1'b1;
				end
			end else begin
				stamp_q <= stamp_new;
				if (pos_q == POS_LAST) begin
					pos_q <= '0;
					if (too_many) begin
						halted_q <= 1'b1;
					end else begin
						bins_before_q <= BIN_W'(nb_q);
						bins_left_q   <= BIN_W'(nb_q);
						bin_ctr_q     <= '0;
						prev_nz_q     <= (stamp_new != '0);
						expect_q      <= {1'b0, stamp_new} + (TIME_W'(nb_q) << SPAN_SH);
					end
				end else begin
					pos_q <= pos_q + POS_W'(1);
				end
			end
		end
	end

endmodule

FILE: rtl/bcrd_queue.sv
// Small circular command queue between the parser and the output side.
// Depends on bcrd_pkg for the command type.
module bcrd_queue #(
	parameter int DEPTH = bcrd_pkg::QUEUE_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  bcrd_pkg::cmd_t push_cmd,
	input  logic           pop,
	output logic           full,
	output logic           not_empty,
	output bcrd_pkg::cmd_t head
);
	import bcrd_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	cmd_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

FILE: rtl/bcrd_back.sv
// Output side: forms the bin time with one add and holds the result register.
// Depends on bcrd_pkg.
module bcrd_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cmd_avail,
	input  bcrd_pkg::cmd_t               cmd,
	output logic                         cmd_pop,
	output logic                         result_valid,
	input  logic                         result_ready,
	output logic [1:0]                   result_kind,
	output logic [bcrd_pkg::TIME_W-1:0]  time_value,
	output logic [bcrd_pkg::DATA_W-1:0]  bin_count,
	output logic [bcrd_pkg::IDX_W-1:0]   bin_number,
	output logic [bcrd_pkg::LEN_W-1:0]   record_length,
	output logic [bcrd_pkg::NB_W-1:0]    bins_in_record,
	output logic                         time_gap,
	output logic                         out_of_order,
	output logic                         last_bin,
	output logic [bcrd_pkg::FMT_W-1:0]   format_seen
);
	import bcrd_pkg::*;

	logic              valid_q;
	cmd_t              res_q;
	logic [TIME_W-1:0] time_q;
	logic              load;
	logic [TIME_W-1:0] time_sum;

	assign load     = !valid_q || result_ready;
	assign cmd_pop  = load && cmd_avail;
	assign time_sum = {1'b0, cmd.stamp} + (TIME_W'(cmd.index) << SPAN_SH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			res_q   <= '0;
			time_q  <= '0;
		end else if (load) begin
			valid_q <= cmd_avail;
			if (cmd_avail) begin
				res_q  <= cmd;
				time_q <= time_sum;
			end
		end
	end

	assign result_valid   = valid_q;
	assign result_kind    = res_q.kind;
	assign time_value     = time_q;
	assign bin_count      = res_q.count;
	assign bin_number     = res_q.index;
	assign record_length  = res_q.length;
	assign bins_in_record = res_q.nbins;
	assign time_gap       = res_q.gap;
	assign out_of_order   = res_q.ooo;
	assign last_bin       = res_q.last;
	assign format_seen    = res_q.format;

endmodule

FILE: rtl/binned_count_record_deframer.sv
// Top level of the binned count record deframer: parser, command queue, output stage.
// Depends on bcrd_pkg, bcrd_front, bcrd_queue and bcrd_back.
//
// Usage:
//   The input channel (data_valid, data_ready, data_byte) carries one stream byte
//   per transaction. Records are a 2-byte length, a 2-byte format word, a 6-byte
//   timestamp and then length minus 10 count bytes, all big-endian.
//   The output channel (result_valid, result_ready and the result fields) carries
//   one header result per record, one bin result per count byte, or one error result.
//   cfg_write_en / cfg_write_data set the expected format word; write it only while
//   the block is idle.
//   Throughput is one byte per cycle while the command queue has room. A byte that
//   produces a result is classified by the parser into the command queue at the
//   accepting edge; the output stage then takes it from the queue, adds the bin
//   offset to the timestamp and registers the result.
//   When the receiver stalls, results collect in the queue; data_ready drops only
//   once the queue is full, so the input side keeps moving through short stalls.
//   After an error result the parser halts: further bytes are still accepted but
//   ignored until reset. Reset (arst_n low) clears the parser, the queue and the
//   output register, and restores the expected format word to 300.
module binned_count_record_deframer #(
	parameter int QUEUE_DEPTH = bcrd_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_write_en,
	input  logic [bcrd_pkg::FMT_W-1:0]   cfg_write_data,
	input  logic                         data_valid,
	output logic                         data_ready,
	input  logic [bcrd_pkg::DATA_W-1:0]  data_byte,
	output logic                         result_valid,
	input  logic                         result_ready,
	output logic [1:0]                   result_kind,
	output logic [bcrd_pkg::TIME_W-1:0]  time_value,
	output logic [bcrd_pkg::DATA_W-1:0]  bin_count,
	output logic [bcrd_pkg::IDX_W-1:0]   bin_number,
	output logic [bcrd_pkg::LEN_W-1:0]   record_length,
	output logic [bcrd_pkg::NB_W-1:0]    bins_in_record,
	output logic                         time_gap,
	output logic                         out_of_order,
	output logic                         last_bin,
	output logic [bcrd_pkg::FMT_W-1:0]   format_seen
);
	import bcrd_pkg::*;

	logic [FMT_W-1:0] expected_format_q;
	logic             byte_accept;
	logic             cmd_push;
	cmd_t             cmd_in;
	logic             q_full;
	logic             q_not_empty;
	logic             q_pop;
	cmd_t             q_head;

	// The expected format word is the only configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_format_q <= FORMAT_RESET;
		end else if (cfg_write_en) begin
			expected_format_q <= cfg_write_data;
		end
	end

	assign data_ready  = !q_full;
	assign byte_accept = data_valid && data_ready;

	bcrd_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.byte_accept     (byte_accept),
		.data_byte       (data_byte),
		.expected_format (expected_format_q),
		.cmd_push        (cmd_push),
		.cmd             (cmd_in)
	);

	bcrd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (cmd_push),
		.push_cmd  (cmd_in),
		.pop       (q_pop),
		.full      (q_full),
		.not_empty (q_not_empty),
		.head      (q_head)
	);

	bcrd_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd_avail      (q_not_empty),
		.cmd            (q_head),
		.cmd_pop        (q_pop),
		.result_valid   (result_valid),
		.result_ready   (result_ready),
		.result_kind    (result_kind),
		.time_value     (time_value),
		.bin_count      (bin_count),
		.bin_number     (bin_number),
		.record_length  (record_length),
		.bins_in_record (bins_in_record),
		.time_gap       (time_gap),
		.out_of_order   (out_of_order),
		.last_bin       (last_bin),
		.format_seen    (format_seen)
	);

endmodule

FILE: rtl/bcrd_checker.sv
// Port-level checks for the binned count record deframer, bound to its top level.
// Depends on bcrd_pkg and binned_count_record_deframer.
module bcrd_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         result_valid,
	input logic                         result_ready,
	input logic [1:0]                   result_kind,
	input logic [bcrd_pkg::TIME_W-1:0]  time_value,
	input logic [bcrd_pkg::DATA_W-1:0]  bin_count,
	input logic [bcrd_pkg::IDX_W-1:0]   bin_number,
	input logic [bcrd_pkg::NB_W-1:0]    bins_in_record,
	input logic                         time_gap,
	input logic                         out_of_order,
	input logic                         last_bin
);
	import bcrd_pkg::*;

	logic halted_seen_q;

	// Set once an error result has been handed over; the block is halted from then on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			halted_seen_q <= 1'b0;
		end else if (result_valid && result_ready &&
			(result_kind == KIND_ERR_FMT || result_kind == KIND_ERR_BIN)) begin
			halted_seen_q <= 1'b1;
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result_kind)
			&& $stable(time_value) && $stable(bin_number))
		else $error("result changed while stalled");

	a_no_result_after_error: assert property (@(posedge clk) disable iff (!arst_n)
		halted_seen_q |-> !result_valid)
		else $error("result after an error result");

	a_flags_header_only: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_kind != KIND_HEADER |-> !time_gap && !out_of_order)
		else $error("timing flags on a result that is not a header");

	a_bin_fields: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_kind != KIND_BIN |-> !last_bin && bin_count == '0
			&& bin_number == '0)
		else $error("bin fields set on a result that is not a bin");

	a_fmt_error_fields: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_kind == KIND_ERR_FMT |-> time_value == '0
			&& bins_in_record == '0)
		else $error("format error carries time or bin count");

endmodule

bind binned_count_record_deframer bcrd_checker u_bcrd_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.result_valid   (result_valid),
	.result_ready   (result_ready),
	.result_kind    (result_kind),
	.time_value     (time_value),
	.bin_count      (bin_count),
	.bin_number     (bin_number),
	.bins_in_record (bins_in_record),
	.time_gap       (time_gap),
	.out_of_order   (out_of_order),
	.last_bin       (last_bin)
);

FILE: verif/binned_count_record_deframer_tb.sv
// Testbench for binned_count_record_deframer: record streams in, headers, bins and errors out.
// Depends on bcrd_pkg and the deframer RTL; the expected results come from a local predictor.
`timescale 1ns / 1ps

module binned_count_record_deframer_tb;
	import bcrd_pkg::*;

	// Run shape. The random part is split over four expected-format settings.
	localparam int RESET_CYCLES  = 7;
	localparam int RANDOM_BYTES  = 1100;
	localparam int SETTLE_CYCLES = 8;   // leave a margin after the last expected result
	localparam int TAIL_CYCLES   = 20;
	localparam int NOISE_BYTES   = 40;

	// One result as the output channel should present it.
	typedef struct {
		kind_t              kind;
		logic [TIME_W-1:0]  tval;
		logic [DATA_W-1:0]  cnt;
		logic [IDX_W-1:0]   num;
		logic [LEN_W-1:0]   len;
		logic [NB_W-1:0]    nb;
		logic               gap;
		logic               ooo;
		logic               last_flag;
		logic [FMT_W-1:0]   fmt;
	} deframed_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_write_en = 1'b0;
	logic [FMT_W-1:0]    cfg_write_data = '0;
	logic                data_valid = 1'b0;
	logic                data_ready;
	logic [DATA_W-1:0]   data_byte = '0;
	logic                result_valid;
	logic                result_ready = 1'b0;
	logic [1:0]          result_kind;
	logic [TIME_W-1:0]   time_value;
	logic [DATA_W-1:0]   bin_count;
	logic [IDX_W-1:0]    bin_number;
	logic [LEN_W-1:0]    record_length;
	logic [NB_W-1:0]     bins_in_record;
	logic                time_gap;
	logic                out_of_order;
	logic                last_bin;
	logic [FMT_W-1:0]    format_seen;

	// Predictor state, at its reset values. stamp_prev of zero means there is no
	// previous record to compare a new timestamp against.
	logic [FMT_W-1:0]    fmt_expected = FORMAT_RESET;
	logic [POS_W-1:0]    hdr_pos = '0;
	logic [LEN_W-1:0]    len_acc = '0;
	logic [FMT_W-1:0]    fmt_acc = '0;
	logic [STAMP_W-1:0]  stamp_acc = '0;
	logic [STAMP_W-1:0]  stamp_prev = '0;
	logic [NB_W-1:0]     nb_prev = '0;
	logic [NB_W-1:0]     bins_left = '0;
	logic [IDX_W-1:0]    bin_idx = '0;
	bit                  halted = 1'b0;

	deframed_t           pending_results[$];

	// Idling control: a quiet side never waits, which gives stretches at full rate.
	bit                  quiet_tx = 1'b0;
	bit                  quiet_rx = 1'b0;

	int                  mismatches = 0;
	int                  bytes_sent = 0;
	int                  n_headers = 0;
	int                  n_bins = 0;
	int                  n_errors = 0;
	int                  n_fmt_writes = 0;
	string               halt_cause = "none";

	binned_count_record_deframer dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write_en   (cfg_write_en),
		.cfg_write_data (cfg_write_data),
		.data_valid     (data_valid),
		.data_ready     (data_ready),
		.data_byte      (data_byte),
		.result_valid   (result_valid),
		.result_ready   (result_ready),
		.result_kind    (result_kind),
		.time_value     (time_value),
		.bin_count      (bin_count),
		.bin_number     (bin_number),
		.record_length  (record_length),
		.bins_in_record (bins_in_record),
		.time_gap       (time_gap),
		.out_of_order   (out_of_order),
		.last_bin       (last_bin),
		.format_seen    (format_seen)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Hard stop in case the block hangs; several times the slowest legal run.
	initial begin
		#10_000_000;
		$display("binned_count_record_deframer test failed");
		$finish;
	end

	function automatic int pick_wait(input bit quiet);
		if (quiet)
			return 0;
		return $urandom_range(0, 13);
	endfunction

	// Queue one expected result. Length and format always reflect the header registers
	// as they stand after the current byte has been absorbed.
	function automatic void record_result(input kind_t kind, input logic [63:0] tval,
			input logic [DATA_W-1:0] cnt, input logic [IDX_W-1:0] num,
			input logic [NB_W-1:0] nb, input logic gap, input logic ooo,
			input logic last_flag);
		deframed_t r;
		r.kind      = kind;
		r.tval      = tval[TIME_W-1:0];
		r.cnt       = cnt;
		r.num       = num;
		r.len       = len_acc;
		r.nb        = nb;
		r.gap       = gap;
		r.ooo       = ooo;
		r.last_flag = last_flag;
		r.fmt       = fmt_acc;
		pending_results.push_back(r);
	endfunction

	// Advance the deframer model by one accepted stream byte.
	function automatic void deframe_byte(input logic [DATA_W-1:0] b);
		int          nb_full;
		logic [63:0] seam;
		logic        ahead;
		logic        behind;
		if (halted)
			return;
		// Inside the count section every byte is a bin.
		if (bins_left != '0) begin
			record_result(KIND_BIN, 64'(stamp_acc) + (64'(bin_idx) << SPAN_SH), b, bin_idx,
				nb_prev, 1'b0, 1'b0, bins_left == 1);
			bins_left--;
			bin_idx++;
			return;
		end
		if (hdr_pos < 2) begin
			len_acc = {len_acc[7:0], b};
			hdr_pos++;
			return;
		end
		if (hdr_pos < 4) begin
			fmt_acc = {fmt_acc[7:0], b};
			hdr_pos++;
			// The register is checked at the moment the low format byte lands.
			if (hdr_pos == 4 && fmt_acc != fmt_expected) begin
				halted = 1'b1;
				record_result(KIND_ERR_FMT, '0, '0, '0, '0, 1'b0, 1'b0, 1'b0);
			end
			return;
		end
		stamp_acc = {stamp_acc[STAMP_W-9:0], b};
		hdr_pos++;
		if (hdr_pos < HDR_BYTES)
			return;
		hdr_pos = '0;
		nb_full = (len_acc >= HDR_BYTES) ? int'(len_acc) - HDR_BYTES : 0;
		if (nb_full > MAX_BINS) begin
			halted = 1'b1;
			record_result(KIND_ERR_BIN, 64'(stamp_acc), '0, '0,
				(nb_full > int'(NB_SAT)) ? NB_SAT : NB_W'(nb_full), 1'b0, 1'b0, 1'b0);
			return;
		end
		seam   = 64'(stamp_prev) + (64'(nb_prev) << SPAN_SH);
		ahead  = 1'b0;
		behind = 1'b0;
		if (stamp_prev != '0) begin
			ahead  = 64'(stamp_acc) > seam;
			behind = 64'(stamp_acc) < seam;
		end
		nb_prev    = NB_W'(nb_full);
		stamp_prev = stamp_acc;
		bins_left  = NB_W'(nb_full);
		bin_idx    = '0;
		record_result(KIND_HEADER, 64'(stamp_acc), '0, '0, NB_W'(nb_full), ahead, behind, 1'b0);
	endfunction

	function automatic void check_field(input string label, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			$display("%0t: %s expected 0x%0h, got 0x%0h", $time, label, want, got);
			mismatches++;
		end
	endfunction

	// Every transaction on the output channel is matched against the oldest expectation.
	always @(posedge clk) begin : result_check
		deframed_t want;
		if (arst_n && result_valid && result_ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: result of kind %0d arrived with nothing expected",
					$time, result_kind);
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				check_field("result_kind", want.kind, result_kind);
				check_field("time_value", want.tval, time_value);
				check_field("bin_count", want.cnt, bin_count);
				check_field("bin_number", want.num, bin_number);
				check_field("record_length", want.len, record_length);
				check_field("bins_in_record", want.nb, bins_in_record);
				check_field("time_gap", want.gap, time_gap);
				check_field("out_of_order", want.ooo, out_of_order);
				check_field("last_bin", want.last_flag, last_bin);
				check_field("format_seen", want.fmt, format_seen);
			end
			case (kind_t'(result_kind))
				KIND_HEADER: n_headers++;
				KIND_BIN:    n_bins++;
				default:     n_errors++;
			endcase
		end
	end

	// Receiver: a fresh stall before every result, ready held until the transaction.
	initial begin : result_sink
		int stall;
		forever begin
			stall = pick_wait(quiet_rx);
			@(negedge clk);
			if (stall > 0) begin
				result_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			result_ready <= 1'b1;
			do @(posedge clk); while (!(result_valid && result_ready));
		end
	end

	// Offer one stream byte after a random gap and return at the edge that takes it.
	// Valid is left high; the next call or settle() decides what happens to it.
	task automatic send_byte(input logic [DATA_W-1:0] b);
		int gap_cycles;
		gap_cycles = pick_wait(quiet_tx);
		@(negedge clk);
		if (gap_cycles > 0) begin
			data_valid <= 1'b0;
			repeat (gap_cycles) @(negedge clk);
		end
		data_byte  <= b;
		data_valid <= 1'b1;
		do @(posedge clk); while (!(data_valid && data_ready));
		deframe_byte(b);
		bytes_sent++;
	endtask

	// Stop offering bytes, let every expected result come out, then allow for
	// header bytes that are still moving through the pipeline without a result.
	task automatic settle();
		@(negedge clk);
		data_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_format(input logic [FMT_W-1:0] value);
		@(negedge clk);
		cfg_write_en   <= 1'b1;
		cfg_write_data <= value;
		@(negedge clk);
		cfg_write_en   <= 1'b0;
		fmt_expected = value;
		n_fmt_writes++;
	endtask

	// Send one full record. With retune set the expected format is rewritten between
	// the two format bytes, so the check must use the new value. Count bytes are not
	// sent once the block has halted.
	task automatic send_record(input logic [LEN_W-1:0] len, input logic [FMT_W-1:0] fmt,
			input logic [STAMP_W-1:0] stamp, input bit extreme_counts, input bit retune);
		int n_counts;
		int i;
		n_counts = (len >= HDR_BYTES) ? int'(len) - HDR_BYTES : 0;
		quiet_tx = ($urandom_range(0, 4) == 0);
		quiet_rx = ($urandom_range(0, 4) == 0);
		send_byte(len[15:8]);
		send_byte(len[7:0]);
		send_byte(fmt[15:8]);
		if (retune) begin
			settle();
			write_format(fmt);
		end
		send_byte(fmt[7:0]);
		for (i = 5; i >= 0; i--)
			send_byte(stamp[i*8 +: 8]);
		for (i = 0; i < n_counts && !halted; i++)
			send_byte(extreme_counts ? ((i % 2) ? 8'hFF : 8'h00) : 8'($urandom_range(0, 255)));
	endtask

	// Mostly short records, a few long ones.
	function automatic logic [LEN_W-1:0] pick_length();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 5)
			return LEN_W'($urandom_range(0, HDR_BYTES - 1));
		if (roll < 75)
			return LEN_W'(HDR_BYTES + $urandom_range(0, 12));
		if (roll < 95)
			return LEN_W'(HDR_BYTES + $urandom_range(13, 64));
		return LEN_W'(HDR_BYTES + $urandom_range(65, 300));
	endfunction

	// Timestamps cluster around the end of the previous record's span, so that the
	// contiguous, gap and out-of-order cases all come up often.
	function automatic logic [STAMP_W-1:0] pick_stamp();
		logic [63:0] seam;
		int          roll;
		seam = 64'(stamp_prev) + (64'(nb_prev) << SPAN_SH);
		roll = $urandom_range(0, 99);
		if (roll < 50)
			return seam[STAMP_W-1:0];
		if (roll < 60)
			return seam[STAMP_W-1:0] + STAMP_W'($urandom_range(1, 200000));
		if (roll < 70)
			return seam[STAMP_W-1:0] - STAMP_W'($urandom_range(1, 200000));
		if (roll < 75)
			return seam[STAMP_W-1:0] + 1;
		if (roll < 80)
			return seam[STAMP_W-1:0] - 1;
		if (roll < 85)
			return '0;
		return {16'($urandom), 32'($urandom)};
	endfunction

	// Lengths below ten carry no bins; the first record has no predecessor.
	task automatic test_short_records();
		send_record(16'd0, fmt_expected, 48'h1234_5678_9ABC, 1'b0, 1'b0);
		send_record(16'd9, fmt_expected, 48'h1234_5678_9ABC, 1'b0, 1'b0);
	endtask

	// A zero timestamp leaves the next record without a predecessor. The all-ones
	// timestamp pushes the second bin time past 48 bits, and the record after it
	// lands far below the expected time.
	task automatic test_stamp_extremes();
		send_record(16'd12, fmt_expected, '0, 1'b1, 1'b0);
		send_record(16'd12, fmt_expected, '1, 1'b1, 1'b0);
		send_record(16'd10, fmt_expected, 48'h0000_0000_0001, 1'b0, 1'b0);
	endtask

	task automatic test_format_change_midrecord();
		send_record(pick_length(), fmt_expected ^ FMT_W'($urandom_range(1, 65535)),
			pick_stamp(), 1'b0, 1'b1);
	endtask

	// The largest record that is still legal: bin numbers run up to 4095.
	task automatic test_max_record();
		send_record(LEN_W'(HDR_BYTES + MAX_BINS), fmt_expected, pick_stamp(), 1'b0, 1'b0);
	endtask

	// Well-formed records with random content under four format settings, the
	// all-zeros and all-ones words among them.
	task automatic test_random_traffic();
		logic [FMT_W-1:0] fmt_plan [4];
		int               phase;
		int               goal;
		fmt_plan[0] = '0;
		fmt_plan[1] = '1;
		fmt_plan[2] = FMT_W'($urandom_range(0, 65535));
		fmt_plan[3] = FORMAT_RESET;
		for (phase = 0; phase < 4; phase++) begin
			settle();
			write_format(fmt_plan[phase]);
			goal = bytes_sent + RANDOM_BYTES / 4;
			while (bytes_sent < goal)
				send_record(pick_length(), fmt_expected, pick_stamp(), 1'b0, 1'b0);
		end
	endtask

	// An error halts the block until reset, and reset happens only once, so each run
	// ends with one error of a randomly chosen kind followed by bytes that must vanish.
	task automatic test_halt();
		logic [LEN_W-1:0] len;
		int               roll;
		int               i;
		if ($urandom_range(0, 1) == 0) begin
			halt_cause = "bad format word";
			send_record(LEN_W'($urandom_range(0, 65535)),
				fmt_expected ^ FMT_W'($urandom_range(1, 65535)), pick_stamp(), 1'b0, 1'b0);
		end else begin
			halt_cause = "too many bins";
			roll = $urandom_range(0, 2);
			if (roll == 0)
				len = LEN_W'(HDR_BYTES + MAX_BINS + 1);
			else if (roll == 1)
				len = '1;
			else
				len = LEN_W'($urandom_range(HDR_BYTES + MAX_BINS + 1, 65535));
			send_record(len, fmt_expected, pick_stamp(), 1'b0, 1'b0);
		end
		for (i = 0; i < NOISE_BYTES; i++)
			send_byte(8'($urandom_range(0, 255)));
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_short_records();
		test_stamp_extremes();
		test_format_change_midrecord();
		test_max_record();
		test_random_traffic();
		test_halt();

		settle();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Sent %0d stream bytes under %0d format settings; checked %0d headers,",
			bytes_sent, n_fmt_writes + 1, n_headers);
		$display("%0d bins and %0d error result(s); the run halted on: %s.",
			n_bins, n_errors, halt_cause);
		if (mismatches == 0)
			$display("binned_count_record_deframer test passed");
		else
			$display("binned_count_record_deframer test failed");
		$finish;
	end

endmodule
